>>> src/scbd_pkg.sv
// Package for the scan-code button decoder: item types, scan codes,
// button bit positions and the code-to-button lookup.
// No dependencies.
package scbd_pkg;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_POLL = 1'b1
    } t_op;

    localparam logic [7:0] PausePrefix  = 8'hE1;
    localparam logic [7:0] ExtPrefix    = 8'hE0;
    localparam logic [2:0] PauseSkipLen = 3'd5;

    // extended set
    localparam logic [6:0] ExtCodeUp    = 7'h48;
    localparam logic [6:0] ExtCodeDown  = 7'h50;
    localparam logic [6:0] ExtCodeLeft  = 7'h4B;
    localparam logic [6:0] ExtCodeRight = 7'h4D;
    // plain set
    localparam logic [6:0] CodeUp       = 7'h11;
    localparam logic [6:0] CodeDown     = 7'h1F;
    localparam logic [6:0] CodeLeft     = 7'h1E;
    localparam logic [6:0] CodeRight    = 7'h20;
    localparam logic [6:0] CodeDash     = 7'h39;
    localparam logic [6:0] CodeConfirm  = 7'h1C;
    localparam logic [6:0] CodeReset    = 7'h13;
    localparam logic [6:0] CodeEscape   = 7'h01;

    localparam logic [7:0] BtnUp      = 8'h01;
    localparam logic [7:0] BtnDown    = 8'h02;
    localparam logic [7:0] BtnLeft    = 8'h04;
    localparam logic [7:0] BtnRight   = 8'h08;
    localparam logic [7:0] BtnDash    = 8'h10;
    localparam logic [7:0] BtnConfirm = 8'h20;
    localparam logic [7:0] BtnReset   = 8'h40;
    localparam logic [7:0] BtnEscape  = 8'h80;
    localparam logic [7:0] BtnNone    = 8'h00;

    typedef struct packed {
        t_op        operation;
        logic [7:0] data_byte;
        logic       aux_source;
    } t_in_item;

    typedef struct packed {
        logic [7:0] held_mask;
        logic [7:0] pressed_mask;
        logic [7:0] released_mask;
    } t_out_item;

    function automatic logic [7:0] lookup_button(input logic [6:0] code, input logic ext);
        logic [7:0] btn;
        btn = BtnNone;
        if (ext) begin
            unique case (code)
                ExtCodeUp:    btn = BtnUp;
                ExtCodeDown:  btn = BtnDown;
                ExtCodeLeft:  btn = BtnLeft;
                ExtCodeRight: btn = BtnRight;
                default:      btn = BtnNone;
            endcase
        end else begin
            unique case (code)
                CodeUp:      btn = BtnUp;
                CodeDown:    btn = BtnDown;
                CodeLeft:    btn = BtnLeft;
                CodeRight:   btn = BtnRight;
                CodeDash:    btn = BtnDash;
                CodeConfirm: btn = BtnConfirm;
                CodeReset:   btn = BtnReset;
                CodeEscape:  btn = BtnEscape;
                default:     btn = BtnNone;
            endcase
        end
        return btn;
    endfunction

endpackage

>>> src/scbd_if.sv
// Valid/ready channel interfaces for the scan-code button decoder:
// byte/poll input channel and button-state result channel. No dependencies.
interface scbd_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] data_byte;
    logic       aux_source;

    modport source (output valid, output operation, output data_byte, output aux_source,
                    input ready);
    modport sink   (input valid, input operation, input data_byte, input aux_source,
                    output ready);
endinterface

interface scbd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] held_mask;
    logic [7:0] pressed_mask;
    logic [7:0] released_mask;

    modport source (output valid, output held_mask, output pressed_mask,
                    output released_mask, input ready);
    modport sink   (input valid, input held_mask, input pressed_mask,
                    input released_mask, output ready);
endinterface

>>> src/scbd_in_reg.sv
// Input register stage: captures one byte/poll transfer per cycle while it is empty or its item is being taken.
// Depends on scbd_pkg and scbd_if.
module scbd_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    scbd_in_if.sink           i_in,
    input  logic              i_take,
    output logic              o_valid,
    output scbd_pkg::t_in_item o_item
);
    import scbd_pkg::*;

    logic     r_valid;
    t_in_item r_item;
    logic     accept;

    assign i_in.ready = !r_valid || i_take;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.operation  <= t_op'(i_in.operation);
            r_item.data_byte  <= i_in.data_byte;
            r_item.aux_source <= i_in.aux_source;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

>>> src/scbd_core.sv
// Decoder state: held mask, extended flag, pause skip count, last polled mask.
// Consumes one registered item per cycle; a poll waits while the result register has no room. Depends on scbd_pkg.
module scbd_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  scbd_pkg::t_in_item i_item,
    input  logic               i_out_room,
    output logic               o_take,
    output logic               o_res_valid,
    output scbd_pkg::t_out_item o_res
);
    import scbd_pkg::*;

    logic [7:0] r_held;
    logic       r_ext;
    logic [2:0] r_skip;
    logic [7:0] r_last;
    logic [7:0] n_held;
    logic       n_ext;
    logic [2:0] n_skip;
    logic [7:0] n_last;
    logic [7:0] btn;
    logic       is_poll;

    assign is_poll     = (i_item.operation == OP_POLL);
    assign o_take      = i_valid && (!is_poll || i_out_room);
    assign o_res_valid = o_take && is_poll;
    assign btn         = lookup_button(i_item.data_byte[6:0], r_ext);

    always_comb begin
        n_held = r_held;
        n_ext  = r_ext;
        n_skip = r_skip;
        n_last = r_last;
        if (o_take) begin
            if (is_poll) begin
                n_last = r_held;
            end else if (!i_item.aux_source) begin
                if (r_skip != 3'd0) begin
                    n_skip = r_skip - 3'd1;
                end else if (i_item.data_byte == PausePrefix) begin
                    n_skip = PauseSkipLen;
                    n_ext  = 1'b0;
                end else if (i_item.data_byte == ExtPrefix) begin
                    n_ext = 1'b1;
                end else begin
                    n_ext = 1'b0;
                    if (i_item.data_byte[7]) begin
                        n_held = r_held & ~btn;
                    end else begin
                        n_held = r_held | btn;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_ext  <= 1'b0;
            r_skip <= '0;
            r_last <= '0;
        end else begin
            r_held <= n_held;
            r_ext  <= n_ext;
            r_skip <= n_skip;
            r_last <= n_last;
        end
    end

    assign o_res.held_mask     = r_held;
    assign o_res.pressed_mask  = r_held & ~r_last;
    assign o_res.released_mask = r_last & ~r_held;

`ifndef SYNTH
    a_skip_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip <= PauseSkipLen)
        else $error("pause skip count out of range");

    a_skip_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && !is_poll && !i_item.aux_source && (r_skip != 3'd0)
        |=> (r_skip == $past(r_skip) - 3'd1) && $stable(r_held) && $stable(r_ext))
        else $error("skipped byte changed decoder state");

    a_poll_snap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> (r_last == $past(r_held)) && $stable(r_held))
        else $error("poll did not capture held mask");

    a_aux_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && !is_poll && i_item.aux_source
        |=> $stable(r_held) && $stable(r_ext) && $stable(r_skip) && $stable(r_last))
        else $error("aux byte changed decoder state");
`endif
endmodule

>>> src/scbd_out_reg.sv
// Result register: holds one poll result until the sink takes the transfer.
// Depends on scbd_pkg and scbd_if.
module scbd_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  scbd_pkg::t_out_item i_res,
    output logic                o_room,
    scbd_out_if.source          o_out
);
    import scbd_pkg::*;

    logic      r_valid;
    t_out_item r_res;

    assign o_room = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_room) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_room && i_valid) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.held_mask     = r_res.held_mask;
    assign o_out.pressed_mask  = r_res.pressed_mask;
    assign o_out.released_mask = r_res.released_mask;
endmodule

>>> src/scan_code_button_decoder.sv
// Scan-code set 1 button decoder, top level.
// Throughput: one byte or poll transfer per cycle; stalls only while a result waits.
// A poll result passes through the input register, which loads at the transfer,
// and then the result register, which loads once it has room.
// Reset (i_rst_n low, synchronous) clears held mask, extended flag, pause count,
// last polled mask and both pipeline valid bits.
module scan_code_button_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    scbd_in_if.sink    i_in,
    scbd_out_if.source o_out
);
    import scbd_pkg::*;

    logic      stage_valid;
    t_in_item  stage_item;
    logic      take;
    logic      res_valid;
    t_out_item res;
    logic      out_room;

    scbd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_valid (stage_valid),
        .o_item  (stage_item)
    );

    scbd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (stage_valid),
        .i_item      (stage_item),
        .i_out_room  (out_room),
        .o_take      (take),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    scbd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_res   (res),
        .o_room  (out_room),
        .o_out   (o_out)
    );
endmodule

>>> sim/scbd_tb_pkg.sv
// Scoreboard for the scan-code button decoder testbench: mirrors held buttons,
// extended flag and pause skipping per input transfer and checks poll reports.
// Depends on scbd_pkg.
package scbd_tb_pkg;
    import scbd_pkg::*;

    class button_scoreboard;
        logic [7:0] held;
        logic       ext_pending;
        logic [2:0] skip_left;
        logic [7:0] last_polled;
        t_out_item  reports_due[$];
        int         failures;

        function new();
            held        = BtnNone;
            ext_pending = 1'b0;
            skip_left   = '0;
            last_polled = BtnNone;
            failures    = 0;
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= 10) begin
                $display("%s", msg);
            end
        endfunction

        function logic [7:0] button_for(logic [6:0] code, logic ext);
            logic [7:0] btn;
            btn = BtnNone;
            if (ext) begin
                case (code)
                    ExtCodeUp:    btn = BtnUp;
                    ExtCodeDown:  btn = BtnDown;
                    ExtCodeLeft:  btn = BtnLeft;
                    ExtCodeRight: btn = BtnRight;
                    default:      btn = BtnNone;
                endcase
            end else begin
                case (code)
                    CodeUp:      btn = BtnUp;
                    CodeDown:    btn = BtnDown;
                    CodeLeft:    btn = BtnLeft;
                    CodeRight:   btn = BtnRight;
                    CodeDash:    btn = BtnDash;
                    CodeConfirm: btn = BtnConfirm;
                    CodeReset:   btn = BtnReset;
                    CodeEscape:  btn = BtnEscape;
                    default:     btn = BtnNone;
                endcase
            end
            return btn;
        endfunction

        function void note_transfer(t_in_item item);
            logic [7:0] btn;
            t_out_item  report;
            if (item.operation == OP_POLL) begin
                report.held_mask     = held;
                report.pressed_mask  = held & ~last_polled;
                report.released_mask = last_polled & ~held;
                reports_due.push_back(report);
                last_polled = held;
            end else if (!item.aux_source) begin
                if (skip_left != '0) begin
                    skip_left = skip_left - 3'd1;
                end else if (item.data_byte == PausePrefix) begin
                    skip_left   = PauseSkipLen;
                    ext_pending = 1'b0;
                end else if (item.data_byte == ExtPrefix) begin
                    ext_pending = 1'b1;
                end else begin
                    btn         = button_for(item.data_byte[6:0], ext_pending);
                    ext_pending = 1'b0;
                    if (item.data_byte[7]) begin
                        held = held & ~btn;
                    end else begin
                        held = held | btn;
                    end
                end
            end
        endfunction

        function void check_poll_report(t_out_item got);
            t_out_item want;
            if (reports_due.size() == 0) begin
                flag($sformatf("unexpected report: held %h pressed %h released %h",
                               got.held_mask, got.pressed_mask, got.released_mask));
                return;
            end
            want = reports_due.pop_front();
            if (got.held_mask !== want.held_mask ||
                got.pressed_mask !== want.pressed_mask ||
                got.released_mask !== want.released_mask) begin
                flag($sformatf({"report mismatch: expected held %h pressed %h released %h,",
                                " got held %h pressed %h released %h"},
                               want.held_mask, want.pressed_mask, want.released_mask,
                               got.held_mask, got.pressed_mask, got.released_mask));
            end
        endfunction

        function void close_out();
            if (reports_due.size() != 0) begin
                flag($sformatf("%0d poll reports never arrived", reports_due.size()));
            end
        endfunction
    endclass

endpackage

>>> sim/testbench.sv
// Top-level testbench for scan_code_button_decoder: directed and random byte/poll
// traffic with sender idling, receiver stalls and a long receiver hold-off.
// Depends on scbd_pkg, scbd_tb_pkg and the scbd_in_if/scbd_out_if interfaces.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import scbd_pkg::*;
    import scbd_tb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 10;

    logic clk = 1'b0;
    logic rst_n;
    int   cycle_count = 0;
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    int   hold_left = 0;
    int   items_counted = 0;
    t_out_item seen;

    button_scoreboard sb = new();

    scbd_in_if  in_bus ();
    scbd_out_if out_bus ();

    scan_code_button_decoder dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: random stalls, plus a counted hold-off when requested
    initial begin
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                out_bus.ready <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                out_bus.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // signals only change at rising edges, so the falling edge sees settled values
    always @(negedge clk) begin
        if (rst_n && out_bus.valid && out_bus.ready) begin
            seen.held_mask     = out_bus.held_mask;
            seen.pressed_mask  = out_bus.pressed_mask;
            seen.released_mask = out_bus.released_mask;
            sb.check_poll_report(seen);
        end
    end

    function automatic logic [6:0] key_code(input int idx, input logic ext);
        logic [6:0] code;
        code = CodeEscape;
        if (ext) begin
            case (idx)
                0:       code = ExtCodeUp;
                1:       code = ExtCodeDown;
                2:       code = ExtCodeLeft;
                default: code = ExtCodeRight;
            endcase
        end else begin
            case (idx)
                0:       code = CodeUp;
                1:       code = CodeDown;
                2:       code = CodeLeft;
                3:       code = CodeRight;
                4:       code = CodeDash;
                5:       code = CodeConfirm;
                6:       code = CodeReset;
                default: code = CodeEscape;
            endcase
        end
        return code;
    endfunction

    // entered and left at a rising edge
    task automatic send_item(input t_op op, input logic [7:0] byte_val, input logic aux);
        t_in_item item;
        logic     took;
        item.operation  = op;
        item.data_byte  = byte_val;
        item.aux_source = aux;
        while ($urandom_range(99) < send_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(posedge clk);
        end
        in_bus.valid      <= 1'b1;
        in_bus.operation  <= op;
        in_bus.data_byte  <= byte_val;
        in_bus.aux_source <= aux;
        do begin
            @(negedge clk);
            took = in_bus.ready;
            @(posedge clk);
        end while (!took);
        sb.note_transfer(item);
        items_counted++;
    endtask

    task automatic send_byte(input logic [7:0] byte_val);
        send_item(OP_BYTE, byte_val, 1'b0);
    endtask

    task automatic send_poll();
        send_item(OP_POLL, 8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    task automatic run_directed();
        int idx;
        send_item(OP_POLL, 8'h00, 1'b0);
        for (idx = 0; idx < 8; idx++) begin
            send_byte({1'b0, key_code(idx, 1'b0)});
        end
        // aux bytes must not release anything
        send_item(OP_BYTE, {1'b1, CodeEscape}, 1'b1);
        send_item(OP_POLL, 8'hFF, 1'b0);
        send_byte(ExtPrefix);
        send_byte({1'b1, ExtCodeUp});
        send_byte(ExtPrefix);
        send_byte(8'h7F);
        send_byte({1'b1, CodeDown});
        send_byte(ExtPrefix);
        // pause start drops the extended flag; skipped bytes include both prefixes
        send_byte(PausePrefix);
        send_byte(ExtPrefix);
        send_byte(PausePrefix);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte({1'b1, CodeEscape});
        send_byte({1'b0, ExtCodeUp});
        send_item(OP_POLL, 8'hFF, 1'b1);
    endtask

    task automatic run_random(input int quota);
        int   start_count;
        int   pick;
        int   idx;
        logic rel;
        start_count = items_counted;
        while (items_counted - start_count < quota) begin
            pick = $urandom_range(99);
            idx  = $urandom_range(7);
            rel  = 1'($urandom_range(1));
            if (pick < 45) begin
                if (idx < 4 && $urandom_range(1) == 1) begin
                    send_byte(ExtPrefix);
                    send_byte({rel, key_code(idx, 1'b1)});
                end else begin
                    send_byte({rel, key_code(idx, 1'b0)});
                end
            end else if (pick < 70) begin
                send_poll();
            end else if (pick < 78) begin
                send_byte(PausePrefix);
                repeat (5) send_byte(8'($urandom_range(255)));
            end else if (pick < 90) begin
                send_byte(8'($urandom_range(255)));
            end else begin
                send_item(OP_BYTE, 8'($urandom_range(255)), 1'b1);
            end
        end
    endtask

    initial begin
        rst_n             <= 1'b0;
        in_bus.valid      <= 1'b0;
        in_bus.operation  <= OP_BYTE;
        in_bus.data_byte  <= 8'h00;
        in_bus.aux_source <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        send_idle_pct = 0;
        stall_pct     = 0;
        run_random(310);

        send_idle_pct = 67;
        stall_pct     = 0;
        run_random(310);

        send_idle_pct = 0;
        stall_pct     = 67;
        run_random(310);

        send_idle_pct = 8;
        stall_pct     = 8;
        run_random(310);

        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = 300;
        run_random(310);

        in_bus.valid <= 1'b0;
        while (sb.reports_due.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.close_out();
        if (sb.failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
